// ----- hw/rtl/ob0ts_pkg.sv -----
// ----------------------------------------------------------------------------
// ob0ts_pkg
// Shared types, token codes and the keyword table of the Oberon-0 scanner.
// ----------------------------------------------------------------------------
package ob0ts_pkg;

	// identifier storage
	localparam int IDENT_MAX_CHARS = 16;
	localparam int IDENT_IDX_W     = $clog2(IDENT_MAX_CHARS);
	localparam int IDENT_CNT_W     = 5;
	localparam int IDENT_OUT_BYTES = 16;

	// number range
	localparam logic [30:0] NUM_LIMIT = 31'h7FFF_FFFF;

	// token queue
	localparam int FIFO_DEPTH   = 8;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
	localparam int FIFO_LEVEL_W = FIFO_PTR_W + 1;
	localparam int MAX_PUSH     = 2;

	// token codes
	localparam logic [5:0] TOK_NULL      = 6'd0;
	localparam logic [5:0] TOK_TIMES     = 6'd1;
	localparam logic [5:0] TOK_DIV       = 6'd2;
	localparam logic [5:0] TOK_MOD       = 6'd3;
	localparam logic [5:0] TOK_AND       = 6'd4;
	localparam logic [5:0] TOK_PLUS      = 6'd5;
	localparam logic [5:0] TOK_MINUS     = 6'd6;
	localparam logic [5:0] TOK_OR        = 6'd7;
	localparam logic [5:0] TOK_EQL       = 6'd8;
	localparam logic [5:0] TOK_NEQ       = 6'd9;
	localparam logic [5:0] TOK_LSS       = 6'd10;
	localparam logic [5:0] TOK_LEQ       = 6'd11;
	localparam logic [5:0] TOK_GTR       = 6'd12;
	localparam logic [5:0] TOK_GEQ       = 6'd13;
	localparam logic [5:0] TOK_PERIOD    = 6'd14;
	localparam logic [5:0] TOK_COMMA     = 6'd15;
	localparam logic [5:0] TOK_COLON     = 6'd16;
	localparam logic [5:0] TOK_RPAREN    = 6'd17;
	localparam logic [5:0] TOK_RBRAK     = 6'd18;
	localparam logic [5:0] TOK_OF        = 6'd19;
	localparam logic [5:0] TOK_THEN      = 6'd20;
	localparam logic [5:0] TOK_DO        = 6'd21;
	localparam logic [5:0] TOK_LPAREN    = 6'd22;
	localparam logic [5:0] TOK_LBRAK     = 6'd23;
	localparam logic [5:0] TOK_NOT       = 6'd24;
	localparam logic [5:0] TOK_BECOMES   = 6'd25;
	localparam logic [5:0] TOK_NUMBER    = 6'd26;
	localparam logic [5:0] TOK_IDENT     = 6'd27;
	localparam logic [5:0] TOK_SEMICOLON = 6'd28;
	localparam logic [5:0] TOK_END       = 6'd29;
	localparam logic [5:0] TOK_ELSE      = 6'd30;
	localparam logic [5:0] TOK_ELSIF     = 6'd31;
	localparam logic [5:0] TOK_IF        = 6'd32;
	localparam logic [5:0] TOK_WHILE     = 6'd33;
	localparam logic [5:0] TOK_ARRAY     = 6'd34;
	localparam logic [5:0] TOK_RECORD    = 6'd35;
	localparam logic [5:0] TOK_CONST     = 6'd36;
	localparam logic [5:0] TOK_TYPE      = 6'd37;
	localparam logic [5:0] TOK_VAR       = 6'd38;
	localparam logic [5:0] TOK_PROCEDURE = 6'd39;
	localparam logic [5:0] TOK_BEGIN     = 6'd40;
	localparam logic [5:0] TOK_MODULE    = 6'd41;
	localparam logic [5:0] TOK_EOF       = 6'd42;

	// keyword table, text right-justified (first character in the highest used byte)
	localparam int KW_COUNT   = 34;
	localparam int KW_MAX_LEN = 9;

	localparam int KW_LEN [KW_COUNT] = '{
		2, 2, 2, 2, 2, 2, 2, 2,
		3, 3, 3, 3, 3,
		4, 4, 4, 4, 4, 4,
		5, 5, 5, 5, 6, 5, 5,
		6, 6, 6, 7, 9, 3, 4, 6
	};

	localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
		"BY", "DO", "IF", "IN", "IS", "OF", "OR", "TO",
		"END", "FOR", "MOD", "NIL", "VAR",
		"CASE", "ELSE", "EXIT", "THEN", "TYPE", "WITH",
		"ARRAY", "BEGIN", "CONST", "ELSIF", "IMPORT", "UNTIL", "WHILE",
		"RECORD", "REPEAT", "RETURN", "POINTER", "PROCEDURE", "DIV", "LOOP", "MODULE"
	};

	localparam logic [5:0] KW_CODE [KW_COUNT] = '{
		TOK_NULL, TOK_DO, TOK_IF, TOK_NULL, TOK_NULL, TOK_OF, TOK_OR, TOK_NULL,
		TOK_END, TOK_NULL, TOK_MOD, TOK_NULL, TOK_VAR,
		TOK_NULL, TOK_ELSE, TOK_NULL, TOK_THEN, TOK_TYPE, TOK_NULL,
		TOK_ARRAY, TOK_BEGIN, TOK_CONST, TOK_ELSIF, TOK_NULL, TOK_NULL, TOK_WHILE,
		TOK_RECORD, TOK_NULL, TOK_NULL, TOK_NULL, TOK_PROCEDURE, TOK_DIV, TOK_NULL,
		TOK_MODULE
	};

	// one result beat
	typedef struct packed {
		logic [5:0]                    code;
		logic [30:0]                   value;
		logic                          overflow;
		logic [IDENT_OUT_BYTES*8-1:0]  chars;
		logic [IDENT_CNT_W-1:0]        length;
		logic                          last;
	} token_t;

	// which of the two token slots are written this cycle
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] code;
	} kw_hit_t;

	// Match the kept identifier against the keyword table; earliest entry wins.
	function automatic kw_hit_t kw_lookup(input logic [IDENT_CNT_W-1:0] len,
			input logic [KW_MAX_LEN*8-1:0] chars);
		kw_hit_t res;
		logic    match;
		int      sh;
		res.hit  = 1'b0;
		res.code = TOK_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			match = (len == IDENT_CNT_W'(KW_LEN[k]));
			for (int j = 0; j < KW_MAX_LEN; j++) begin
				sh = (j < KW_LEN[k]) ? (KW_LEN[k] - 1 - j) : 0;
				if (j < KW_LEN[k] && chars[j*8 +: 8] != KW_TEXT[k][sh*8 +: 8]) begin
					match = 1'b0;
				end
			end
			if (match) begin
				res.hit  = 1'b1;
				res.code = KW_CODE[k];
			end
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/ob0ts_scan_core.sv -----
// ----------------------------------------------------------------------------
// ob0ts_scan_core
// Input register, scanner state and the single-pass token decision that
// yields up to two tokens per source beat.
// ----------------------------------------------------------------------------
module ob0ts_scan_core
	import ob0ts_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    src_valid,
	output logic                    src_stall,
	input  logic [7:0]              source_byte,
	input  logic                    end_mark,
	input  logic [FIFO_LEVEL_W-1:0] fifo_level,
	output push_t                   push,
	output token_t                  tok_a,
	output token_t                  tok_b
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_LESS,
		MODE_GREATER,
		MODE_COLON,
		MODE_LPAREN,
		MODE_NUMBER,
		MODE_IDENT
	} mode_t;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_AMP     = "&";
	localparam logic [7:0] CH_STAR    = "*";
	localparam logic [7:0] CH_PLUS    = "+";
	localparam logic [7:0] CH_MINUS   = "-";
	localparam logic [7:0] CH_EQUAL   = "=";
	localparam logic [7:0] CH_HASH    = "#";
	localparam logic [7:0] CH_SEMI    = ";";
	localparam logic [7:0] CH_COMMA   = ",";
	localparam logic [7:0] CH_DOT     = ".";
	localparam logic [7:0] CH_RPAREN  = ")";
	localparam logic [7:0] CH_LBRAK   = "[";
	localparam logic [7:0] CH_RBRAK   = "]";
	localparam logic [7:0] CH_TILDE   = "~";
	localparam logic [7:0] CH_LESS    = "<";
	localparam logic [7:0] CH_GREATER = ">";
	localparam logic [7:0] CH_COLON   = ":";
	localparam logic [7:0] CH_LPAREN  = "(";
	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_NINE    = "9";
	localparam logic [7:0] CH_UP_A    = "A";
	localparam logic [7:0] CH_UP_Z    = "Z";
	localparam logic [7:0] CH_LO_A    = "a";
	localparam logic [7:0] CH_LO_Z    = "z";

	// input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   end_s1;

	// scanner state
	mode_t                  mode_q;
	logic [7:0]             ident_buf_q [IDENT_MAX_CHARS];
	logic [IDENT_CNT_W-1:0] ident_cnt_q;
	logic [30:0]            num_acc_q;
	logic                   num_ovf_q;

	// next state
	mode_t                  mode_d;
	logic [IDENT_CNT_W-1:0] ident_cnt_d;
	logic [30:0]            num_acc_d;
	logic                   num_ovf_d;
	logic                   buf_we;
	logic [IDENT_IDX_W-1:0] buf_idx;

	logic                   src_take;
	logic [FIFO_LEVEL_W:0]  room_need;

	logic                   is_dig;
	logic                   is_alp;
	logic [3:0]             digit;
	logic [34:0]            num_next;
	logic                   num_fits;

	logic [IDENT_OUT_BYTES*8-1:0] id_chars;
	kw_hit_t                kw;
	logic [5:0]             ident_tok;

	logic                   s_emit;
	logic [5:0]             s_code;
	mode_t                  s_mode;
	logic                   s_num;
	logic                   s_id;

	logic                   flush;
	logic                   use_start;
	logic                   a_emit;
	logic [5:0]             a_code;
	logic                   b_emit;
	logic [5:0]             b_code;

	// Stall unless the queue can absorb the beat in flight and this one.
	assign room_need = (FIFO_LEVEL_W+1)'(fifo_level)
			+ (valid_s1 ? (FIFO_LEVEL_W+1)'(MAX_PUSH) : '0)
			+ (FIFO_LEVEL_W+1)'(MAX_PUSH);
	assign src_stall = room_need > (FIFO_LEVEL_W+1)'(FIFO_DEPTH);
	assign src_take  = src_valid && !src_stall;

	// Classify the registered byte.
	assign is_dig = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign is_alp = ((byte_s1 >= CH_UP_A) && (byte_s1 <= CH_UP_Z))
			|| ((byte_s1 >= CH_LO_A) && (byte_s1 <= CH_LO_Z));
	assign digit  = 4'(byte_s1 - CH_ZERO);

	// Accumulate one decimal digit: value*10 + digit, checked against the limit.
	assign num_next = 35'({num_acc_q, 3'b000}) + 35'({num_acc_q, 1'b0}) + 35'(digit);
	assign num_fits = num_next <= 35'(NUM_LIMIT);

	// Present kept characters, zero past the count.
	for (genvar i = 0; i < IDENT_OUT_BYTES; i++) begin : g_id_byte
		if (i < IDENT_MAX_CHARS) begin : g_kept
			assign id_chars[i*8 +: 8] =
					(ident_cnt_q > IDENT_CNT_W'(i)) ? ident_buf_q[i] : 8'h00;
		end else begin : g_pad
			assign id_chars[i*8 +: 8] = 8'h00;
		end
	end

	// Keyword match on the leading characters.
	assign kw        = kw_lookup(ident_cnt_q, id_chars[KW_MAX_LEN*8-1:0]);
	assign ident_tok = kw.hit ? kw.code : TOK_IDENT;

	// Decode a byte that starts a fresh token.
	always_comb begin
		s_emit = 1'b0;
		s_code = TOK_NULL;
		s_mode = MODE_IDLE;
		s_num  = 1'b0;
		s_id   = 1'b0;
		if (byte_s1 > CH_SPACE) begin
			case (byte_s1)
				CH_AMP:     begin s_emit = 1'b1; s_code = TOK_AND;       end
				CH_STAR:    begin s_emit = 1'b1; s_code = TOK_TIMES;     end
				CH_PLUS:    begin s_emit = 1'b1; s_code = TOK_PLUS;      end
				CH_MINUS:   begin s_emit = 1'b1; s_code = TOK_MINUS;     end
				CH_EQUAL:   begin s_emit = 1'b1; s_code = TOK_EQL;       end
				CH_HASH:    begin s_emit = 1'b1; s_code = TOK_NEQ;       end
				CH_SEMI:    begin s_emit = 1'b1; s_code = TOK_SEMICOLON; end
				CH_COMMA:   begin s_emit = 1'b1; s_code = TOK_COMMA;     end
				CH_DOT:     begin s_emit = 1'b1; s_code = TOK_PERIOD;    end
				CH_RPAREN:  begin s_emit = 1'b1; s_code = TOK_RPAREN;    end
				CH_LBRAK:   begin s_emit = 1'b1; s_code = TOK_LBRAK;     end
				CH_RBRAK:   begin s_emit = 1'b1; s_code = TOK_RBRAK;     end
				CH_TILDE:   begin s_emit = 1'b1; s_code = TOK_NOT;       end
				CH_LESS:    s_mode = MODE_LESS;
				CH_GREATER: s_mode = MODE_GREATER;
				CH_COLON:   s_mode = MODE_COLON;
				CH_LPAREN:  s_mode = MODE_LPAREN;
				default: begin
					if (is_dig) begin
						s_num  = 1'b1;
						s_mode = MODE_NUMBER;
					end else if (is_alp) begin
						s_id   = 1'b1;
						s_mode = MODE_IDENT;
					end else begin
						s_emit = 1'b1;
					end
				end
			endcase
		end
	end

	// Decide the tokens and the next state for the registered beat.
	always_comb begin
		mode_d      = mode_q;
		ident_cnt_d = ident_cnt_q;
		num_acc_d   = num_acc_q;
		num_ovf_d   = num_ovf_q;
		buf_we      = 1'b0;
		buf_idx     = ident_cnt_q[IDENT_IDX_W-1:0];
		flush       = 1'b0;
		use_start   = 1'b0;
		b_emit      = 1'b0;
		b_code      = TOK_NULL;

		if (valid_s1) begin
			if (end_s1) begin
				flush  = 1'b1;
				b_emit = 1'b1;
				b_code = TOK_EOF;
			end else begin
				case (mode_q)
					MODE_LESS, MODE_GREATER, MODE_COLON: begin
						if (byte_s1 == CH_EQUAL) begin
							b_emit = 1'b1;
							b_code = (mode_q == MODE_LESS) ? TOK_LEQ :
									(mode_q == MODE_GREATER) ? TOK_GEQ : TOK_BECOMES;
							mode_d = MODE_IDLE;
						end else begin
							flush     = 1'b1;
							use_start = 1'b1;
						end
					end
					MODE_NUMBER: begin
						if (is_dig) begin
							num_acc_d = num_fits ? num_next[30:0] : '0;
							num_ovf_d = num_ovf_q || !num_fits;
						end else begin
							flush     = 1'b1;
							use_start = 1'b1;
						end
					end
					MODE_IDENT: begin
						if (is_dig || is_alp) begin
							if (ident_cnt_q < IDENT_CNT_W'(IDENT_MAX_CHARS)) begin
								buf_we      = 1'b1;
								ident_cnt_d = ident_cnt_q + 1'b1;
							end
						end else begin
							flush     = 1'b1;
							use_start = 1'b1;
						end
					end
					MODE_LPAREN: begin
						flush     = 1'b1;
						use_start = 1'b1;
					end
					default: begin
						use_start = 1'b1;
					end
				endcase
			end

			if (flush) begin
				mode_d = MODE_IDLE;
			end
			if (use_start) begin
				b_emit = s_emit;
				b_code = s_code;
				mode_d = s_mode;
				if (s_num) begin
					num_acc_d = 31'(digit);
					num_ovf_d = 1'b0;
				end
				if (s_id) begin
					buf_we      = 1'b1;
					buf_idx     = '0;
					ident_cnt_d = IDENT_CNT_W'(1);
				end
			end
		end
	end

	// Token held pending, emitted when the beat ends it.
	always_comb begin
		a_emit = 1'b0;
		a_code = TOK_NULL;
		if (flush) begin
			case (mode_q)
				MODE_LESS:    begin a_emit = 1'b1; a_code = TOK_LSS;    end
				MODE_GREATER: begin a_emit = 1'b1; a_code = TOK_GTR;    end
				MODE_COLON:   begin a_emit = 1'b1; a_code = TOK_COLON;  end
				MODE_LPAREN:  begin a_emit = 1'b1; a_code = TOK_LPAREN; end
				MODE_NUMBER:  begin a_emit = 1'b1; a_code = TOK_NUMBER; end
				MODE_IDENT:   begin a_emit = 1'b1; a_code = ident_tok;  end
				default:      a_emit = 1'b0;
			endcase
		end
	end

	// Assemble the two token slots.
	always_comb begin
		tok_a          = '0;
		tok_a.code     = a_code;
		tok_a.last     = !b_emit;
		if (a_code == TOK_NUMBER) begin
			tok_a.value    = num_acc_q;
			tok_a.overflow = num_ovf_q;
		end
		if (a_code == TOK_IDENT) begin
			tok_a.chars  = id_chars;
			tok_a.length = ident_cnt_q;
		end
		tok_b      = '0;
		tok_b.code = b_code;
		tok_b.last = 1'b1;
	end

	assign push.first  = a_emit;
	assign push.second = b_emit;

	// Hold control state and the beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mode_q      <= MODE_IDLE;
			ident_cnt_q <= '0;
			num_acc_q   <= '0;
			num_ovf_q   <= 1'b0;
		end else begin
			valid_s1    <= src_take;
			mode_q      <= mode_d;
			ident_cnt_q <= ident_cnt_d;
			num_acc_q   <= num_acc_d;
			num_ovf_q   <= num_ovf_d;
		end
	end

	// Capture the accepted beat.
	always_ff @(posedge clk) begin
		if (src_take) begin
			byte_s1 <= source_byte;
			end_s1  <= end_mark;
		end
	end

	// Store identifier characters.
	always_ff @(posedge clk) begin
		if (buf_we) begin
			ident_buf_q[buf_idx] <= byte_s1;
		end
	end

endmodule

// ----- hw/rtl/ob0ts_token_fifo.sv -----
// ----------------------------------------------------------------------------
// ob0ts_token_fifo
// Token queue that takes up to two tokens a cycle and hands out one beat.
// ----------------------------------------------------------------------------
module ob0ts_token_fifo
	import ob0ts_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  push_t                   push,
	input  token_t                  tok_a,
	input  token_t                  tok_b,
	output logic [FIFO_LEVEL_W-1:0] level,
	output logic                    tok_valid,
	input  logic                    tok_stall,
	output token_t                  head_tok
);

	token_t                  store_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   head_q;
	logic [FIFO_PTR_W-1:0]   tail_q;
	logic [FIFO_LEVEL_W-1:0] level_q;

	logic                    pop;
	logic [1:0]              n_push;
	logic [FIFO_PTR_W-1:0]   second_idx;

	assign tok_valid  = level_q != '0;
	assign pop        = tok_valid && !tok_stall;
	assign n_push     = 2'(push.first) + 2'(push.second);
	assign second_idx = push.first ? tail_q + 1'b1 : tail_q;
	assign level      = level_q;
	assign head_tok   = store_q[head_q];

	// Advance pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			head_q  <= head_q + FIFO_PTR_W'(pop);
			tail_q  <= tail_q + FIFO_PTR_W'(n_push);
			level_q <= level_q + FIFO_LEVEL_W'(n_push) - FIFO_LEVEL_W'(pop);
		end
	end

	// Write the pending token first, then the one the byte itself gives.
	always_ff @(posedge clk) begin
		if (push.first) begin
			store_q[tail_q] <= tok_a;
		end
		if (push.second) begin
			store_q[second_idx] <= tok_b;
		end
	end

endmodule

// ----- hw/rtl/oberon0_token_scanner_top.sv -----
// ----------------------------------------------------------------------------
// oberon0_token_scanner_top
// Oberon-0 lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Source channel: one byte per beat (src_valid / src_stall), or an end mark
// that flushes the pending token and yields eof. Token channel: one token per
// beat (tok_valid / tok_stall) with its number and identifier fields;
// last_of_run marks the final token caused by one source beat.
// A source beat gives zero, one or two tokens. It is registered on accept,
// decided in the next cycle and written into the token queue, whose head
// drives the token port. One source beat is taken per cycle while the queue
// has room; the token side moves one token per cycle while tok_stall is low,
// so a run of two-token beats is paced by the output port.
// The eight-entry token queue absorbs receiver stalls; src_stall rises once
// the queue could not take two tokens for the beat in the input register and
// two more for a new one, and a stalled token beat holds its payload.
// Reset clears the scanner to idle and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module oberon0_token_scanner_top
	import ob0ts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_mark,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [5:0]  token_code,
	output logic [30:0] number_value,
	output logic        number_overflow,
	output logic [63:0] ident_chars_low,
	output logic [63:0] ident_chars_high,
	output logic [4:0]  ident_length,
	output logic        last_of_run
);

	push_t                   push;
	token_t                  tok_a;
	token_t                  tok_b;
	token_t                  head_tok;
	logic [FIFO_LEVEL_W-1:0] fifo_level;

	ob0ts_scan_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.source_byte (source_byte),
		.end_mark    (end_mark),
		.fifo_level  (fifo_level),
		.push        (push),
		.tok_a       (tok_a),
		.tok_b       (tok_b)
	);

	ob0ts_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.tok_a     (tok_a),
		.tok_b     (tok_b),
		.level     (fifo_level),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.head_tok  (head_tok)
	);

	// Split the head token onto the output fields.
	assign token_code       = head_tok.code;
	assign number_value     = head_tok.value;
	assign number_overflow  = head_tok.overflow;
	assign ident_chars_low  = head_tok.chars[63:0];
	assign ident_chars_high = head_tok.chars[127:64];
	assign ident_length     = head_tok.length;
	assign last_of_run      = head_tok.last;

endmodule

// ----- hw/rtl/ob0ts_checker.sv -----
// ----------------------------------------------------------------------------
// ob0ts_checker
// Port-level checks on the token channel of the scanner.
// ----------------------------------------------------------------------------
module ob0ts_checker
	import ob0ts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tok_valid,
	input  logic        tok_stall,
	input  logic [5:0]  token_code,
	input  logic [30:0] number_value,
	input  logic        number_overflow,
	input  logic [63:0] ident_chars_low,
	input  logic [63:0] ident_chars_high,
	input  logic [4:0]  ident_length,
	input  logic        last_of_run
);

	// A stalled token beat holds.
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(token_code)
			&& $stable(number_value) && $stable(ident_length) && $stable(last_of_run))
		else $error("token beat changed while stalled");

	// End of input always closes a run.
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_code == TOK_EOF |-> last_of_run)
		else $error("eof token not marked last of run");

	// Number fields only on number tokens.
	a_num_fields: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_code != TOK_NUMBER |-> number_value == '0 && !number_overflow)
		else $error("number fields set on a non-number token");

	// Identifier fields only on identifier tokens.
	a_id_fields: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && token_code != TOK_IDENT |->
			ident_length == '0 && ident_chars_low == '0 && ident_chars_high == '0)
		else $error("identifier fields set on a non-identifier token");

endmodule

bind oberon0_token_scanner_top ob0ts_checker u_checker (.*);
